>>> rtl/epbt_pkg.sv
package epbt_pkg;

    localparam int COORD_BITS = 24;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int MULT_W     = 16;
    localparam int MULT_SHIFT = 16;
    localparam int ID_W       = 8;

    localparam int MAX_BOXES = 64;
    localparam int MAX_ENT   = 8;
    localparam int BOX_AW    = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int E_AW      = $clog2(MAX_ENT);
    localparam int ECNT_W    = $clog2(MAX_ENT + 1);
    localparam int ENT_AW    = BOX_AW + E_AW;

    localparam int MUL_W   = 32;
    localparam int DIST_W  = 2 * COORD_BITS + 2;
    localparam int S_W     = HALF_BITS + MULT_W;
    localparam int S_HI_W  = S_W - MUL_W;
    localparam int LIM_W   = 2 * S_W;

    localparam logic [15:0] MULT_RESET = 16'd256;

    localparam logic [1:0] ACT_BOX    = 2'd0;
    localparam logic [1:0] ACT_ENT    = 2'd1;
    localparam logic [1:0] ACT_CHECK  = 2'd2;
    localparam logic [1:0] ACT_INSIDE = 2'd3;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_UPDATED  = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTRY = 2'd1;
    localparam logic [1:0] EV_EXIT  = 2'd2;

    typedef logic [2:0][COORD_BITS-1:0] coord3_t;
    typedef logic [2:0][HALF_BITS-1:0]  half3_t;

    typedef struct packed {
        logic [1:0]                   action;
        logic [ID_W-1:0]              building_id;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [HALF_BITS-1:0]         half_x;
        logic [HALF_BITS-1:0]         half_y;
        logic [HALF_BITS-1:0]         half_z;
        logic [HALF_BITS-1:0]         radius;
    } req_item_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic                         hit;
        logic [ID_W-1:0]              building_out;
        logic [1:0]                   event_res;
        logic signed [COORD_BITS-1:0] entrance_x;
        logic signed [COORD_BITS-1:0] entrance_y;
        logic signed [COORD_BITS-1:0] entrance_z;
    } rsp_item_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS])
        begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

endpackage

>>> rtl/epbt_if.sv
interface epbt_req_if import epbt_pkg::*; ();
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface epbt_rsp_if import epbt_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface epbt_cfg_if import epbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MULT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/epbt_mul.sv
module epbt_mul import epbt_pkg::*;
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   p
);

    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> rtl/entrance_proximity_and_box_test.sv
// Channel | Dir | Handshake    | Carries
// req     | in  | valid/ready  | action, id, position, half-size, radius
// rsp     | out | valid/ready  | status, hit, id, event, entrance point
// cfg     | in  | valid/ready  | entry_multiplier (always ready)
//
// One item at a time through a sequencer around one registered 32x32 multiplier.
// Action 0/1: stored boxes are read one by one and compared to find the id.
// Action 2: every stored entrance of every box is measured (three multiplier passes
// and an accumulate), then the nearest one gets the radius test.
// Action 3: boxes are tested in order until a hit. Memories need no clearing after reset.
// A waiting result is held in the output register; a new item is taken meanwhile.
module entrance_proximity_and_box_test import epbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    epbt_req_if.sink    req,
    epbt_rsp_if.source  rsp,
    epbt_cfg_if.sink    cfg
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_FIND_RD  = 5'd1;
    localparam logic [4:0] S_FIND_CHK = 5'd2;
    localparam logic [4:0] S_BOX_RD   = 5'd3;
    localparam logic [4:0] S_BOX_CHK  = 5'd4;
    localparam logic [4:0] S_ENT_RD   = 5'd5;
    localparam logic [4:0] S_D0       = 5'd6;
    localparam logic [4:0] S_D1       = 5'd7;
    localparam logic [4:0] S_D2       = 5'd8;
    localparam logic [4:0] S_D3       = 5'd9;
    localparam logic [4:0] S_R0       = 5'd10;
    localparam logic [4:0] S_R1       = 5'd11;
    localparam logic [4:0] S_R2       = 5'd12;
    localparam logic [4:0] S_R3       = 5'd13;
    localparam logic [4:0] S_R4       = 5'd14;
    localparam logic [4:0] S_R5       = 5'd15;
    localparam logic [4:0] S_DECIDE   = 5'd16;
    localparam logic [4:0] S_IN_RD    = 5'd17;
    localparam logic [4:0] S_IN_CHK   = 5'd18;
    localparam logic [4:0] S_DONE     = 5'd19;

    logic [4:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  bi_reg, bi_next;
    logic [ECNT_W-1:0] ei_reg, ei_next;
    logic [MULT_W-1:0] mult_reg;
    logic              nv_reg, nv_next;
    logic [ID_W-1:0]   nk_reg, nk_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    req_item_t         item_reg, item_next;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [ID_W-1:0]   bkey_reg, bkey_next;
    coord3_t           bpt_reg, bpt_next;
    logic [HALF_BITS-1:0] brad_reg, brad_next;
    logic [S_W-1:0]    s_reg, s_next;
    logic [LIM_W-1:0]  lim_reg, lim_next;
    rsp_item_t         res_reg, res_next;
    rsp_item_t         out_reg, out_next;

    logic [ID_W-1:0]      key_mem [MAX_BOXES];
    coord3_t              cen_mem [MAX_BOXES];
    half3_t               half_mem [MAX_BOXES];
    logic [ECNT_W-1:0]    ecnt_mem [MAX_BOXES];
    coord3_t              pt_mem [MAX_BOXES*MAX_ENT];
    logic [HALF_BITS-1:0] rad_mem [MAX_BOXES*MAX_ENT];

    logic [ID_W-1:0]      key_q;
    coord3_t              cen_q;
    half3_t               half_q;
    logic [ECNT_W-1:0]    ecnt_q;
    coord3_t              pt_q;
    logic [HALF_BITS-1:0] rad_q;

    logic                 key_we, box_we, ecnt_we, ent_we;
    logic [BOX_AW-1:0]    box_wa, box_ra;
    logic [ECNT_W-1:0]    ecnt_wd;
    logic [ENT_AW-1:0]    ent_wa, ent_ra;

    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   prod;

    coord3_t              item_pt;
    half3_t               item_half;
    logic [DIST_W-1:0]    dist_sum;
    logic [LIM_W-1:0]     lhs;
    logic                 near;
    logic                 in_box;

    epbt_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign item_pt   = {item_reg.pos_z, item_reg.pos_y, item_reg.pos_x};
    assign item_half = {item_reg.half_z, item_reg.half_y, item_reg.half_x};
    assign box_ra    = bi_reg[BOX_AW-1:0];
    assign ent_ra    = {bi_reg[BOX_AW-1:0], ei_reg[E_AW-1:0]};
    assign ent_wa    = {bi_reg[BOX_AW-1:0], ecnt_q[E_AW-1:0]};
    assign dist_sum  = acc_reg + DIST_W'(prod);
    assign lhs       = LIM_W'({best_reg, {MULT_SHIFT{1'b0}}});
    assign near      = found_reg && (lhs <= lim_reg);

    always_comb
    begin
        in_box = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (abs_diff(item_pt[k], cen_q[k]) > COORD_BITS'(half_q[k]))
            begin
                in_box = 1'b0;
            end
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_D0:
            begin
                mul_a = MUL_W'(abs_diff(item_pt[0], pt_q[0]));
                mul_b = mul_a;
            end
            S_D1:
            begin
                mul_a = MUL_W'(abs_diff(item_pt[1], pt_q[1]));
                mul_b = mul_a;
            end
            S_D2:
            begin
                mul_a = MUL_W'(abs_diff(item_pt[2], pt_q[2]));
                mul_b = mul_a;
            end
            S_R0:
            begin
                mul_a = MUL_W'(brad_reg);
                mul_b = MUL_W'(mult_reg);
            end
            S_R2:
            begin
                mul_a = s_reg[MUL_W-1:0];
                mul_b = s_reg[MUL_W-1:0];
            end
            S_R3:
            begin
                mul_a = s_reg[MUL_W-1:0];
                mul_b = MUL_W'(s_reg[S_W-1:MUL_W]);
            end
            S_R4:
            begin
                mul_a = MUL_W'(s_reg[S_W-1:MUL_W]);
                mul_b = MUL_W'(s_reg[S_W-1:MUL_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        bi_next        = bi_reg;
        ei_next        = ei_reg;
        nv_next        = nv_reg;
        nk_next        = nk_reg;
        found_next     = found_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        bkey_next      = bkey_reg;
        bpt_next       = bpt_reg;
        brad_next      = brad_reg;
        s_next         = s_reg;
        lim_next       = lim_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        key_we         = 1'b0;
        box_we         = 1'b0;
        ecnt_we        = 1'b0;
        ent_we         = 1'b0;
        box_wa         = bi_reg[BOX_AW-1:0];
        ecnt_wd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    bi_next    = '0;
                    found_next = 1'b0;
                    res_next   = '0;
                    case (req.data.action)
                        ACT_BOX, ACT_ENT: state_next = S_FIND_RD;
                        ACT_CHECK:        state_next = S_BOX_RD;
                        default:          state_next = S_IN_RD;
                    endcase
                end
            end
            S_FIND_RD:
            begin
                if (bi_reg == count_reg)
                begin
                    state_next = S_DONE;
                    if (item_reg.action == ACT_ENT)
                    begin
                        res_next.status = STAT_NOTFOUND;
                    end
                    else if (count_reg >= CNT_W'(MAX_BOXES))
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        box_wa          = count_reg[BOX_AW-1:0];
                        key_we          = 1'b1;
                        box_we          = 1'b1;
                        ecnt_we         = 1'b1;
                        ecnt_wd         = '0;
                        count_next      = count_reg + 1'b1;
                        res_next.status = STAT_DONE;
                    end
                end
                else
                begin
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK:
            begin
                if (key_q == item_reg.building_id)
                begin
                    state_next = S_DONE;
                    if (item_reg.action == ACT_BOX)
                    begin
                        box_we          = 1'b1;
                        res_next.status = STAT_UPDATED;
                    end
                    else if (ecnt_q >= ECNT_W'(MAX_ENT))
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        ent_we          = 1'b1;
                        ecnt_we         = 1'b1;
                        ecnt_wd         = ecnt_q + 1'b1;
                        res_next.status = STAT_DONE;
                    end
                end
                else
                begin
                    bi_next    = bi_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_BOX_RD:
            begin
                if (bi_reg == count_reg)
                begin
                    state_next = found_reg ? S_R0 : S_DECIDE;
                end
                else
                begin
                    state_next = S_BOX_CHK;
                end
            end
            S_BOX_CHK:
            begin
                ei_next    = '0;
                state_next = S_ENT_RD;
            end
            S_ENT_RD:
            begin
                if (ei_reg == ecnt_q)
                begin
                    bi_next    = bi_reg + 1'b1;
                    state_next = S_BOX_RD;
                end
                else
                begin
                    state_next = S_D0;
                end
            end
            S_D0:
            begin
                state_next = S_D1;
            end
            S_D1:
            begin
                acc_next   = DIST_W'(prod);
                state_next = S_D2;
            end
            S_D2:
            begin
                acc_next   = dist_sum;
                state_next = S_D3;
            end
            S_D3:
            begin
                if (!found_reg || dist_sum < best_reg)
                begin
                    found_next = 1'b1;
                    best_next  = dist_sum;
                    bkey_next  = key_q;
                    bpt_next   = pt_q;
                    brad_next  = rad_q;
                end
                ei_next    = ei_reg + 1'b1;
                state_next = S_ENT_RD;
            end
            S_R0:
            begin
                state_next = S_R1;
            end
            S_R1:
            begin
                s_next     = prod[S_W-1:0];
                state_next = S_R2;
            end
            S_R2:
            begin
                state_next = S_R3;
            end
            S_R3:
            begin
                lim_next   = LIM_W'(prod);
                state_next = S_R4;
            end
            S_R4:
            begin
                lim_next   = lim_reg + (LIM_W'(prod) << (MUL_W + 1));
                state_next = S_R5;
            end
            S_R5:
            begin
                lim_next   = lim_reg + (LIM_W'(prod) << (2 * MUL_W));
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                res_next.hit          = near;
                res_next.building_out = found_reg ? bkey_reg : '0;
                if (near)
                begin
                    if (!nv_reg || nk_reg != bkey_reg)
                    begin
                        nv_next             = 1'b1;
                        nk_next             = bkey_reg;
                        res_next.event_res  = EV_ENTRY;
                        res_next.entrance_x = bpt_reg[0];
                        res_next.entrance_y = bpt_reg[1];
                        res_next.entrance_z = bpt_reg[2];
                    end
                end
                else if (nv_reg)
                begin
                    nv_next            = 1'b0;
                    nk_next            = '0;
                    res_next.event_res = EV_EXIT;
                end
                state_next = S_DONE;
            end
            S_IN_RD:
            begin
                state_next = (bi_reg == count_reg) ? S_DONE : S_IN_CHK;
            end
            S_IN_CHK:
            begin
                if (in_box)
                begin
                    res_next.hit          = 1'b1;
                    res_next.building_out = key_q;
                    state_next            = S_DONE;
                end
                else
                begin
                    bi_next    = bi_reg + 1'b1;
                    state_next = S_IN_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            bi_reg        <= '0;
            ei_reg        <= '0;
            mult_reg      <= MULT_RESET;
            nv_reg        <= 1'b0;
            nk_reg        <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bi_reg        <= bi_next;
            ei_reg        <= ei_next;
            nv_reg        <= nv_next;
            nk_reg        <= nk_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                mult_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        acc_reg  <= acc_next;
        best_reg <= best_next;
        bkey_reg <= bkey_next;
        bpt_reg  <= bpt_next;
        brad_reg <= brad_next;
        s_reg    <= s_next;
        lim_reg  <= lim_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[box_wa] <= item_reg.building_id;
        end
        key_q <= key_mem[box_ra];
    end

    always_ff @(posedge clk)
    begin
        if (box_we)
        begin
            cen_mem[box_wa]  <= item_pt;
            half_mem[box_wa] <= item_half;
        end
        cen_q  <= cen_mem[box_ra];
        half_q <= half_mem[box_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ecnt_we)
        begin
            ecnt_mem[box_wa] <= ecnt_wd;
        end
        ecnt_q <= ecnt_mem[box_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            pt_mem[ent_wa]  <= item_pt;
            rad_mem[ent_wa] <= item_reg.radius;
        end
        pt_q  <= pt_mem[ent_ra];
        rad_q <= rad_mem[ent_ra];
    end

endmodule

>>> rtl/epbt_chk.sv
module epbt_chk import epbt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("rsp item changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken while busy");

    a_entry_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.event_res == EV_ENTRY |-> rsp_data.hit)
        else $error("entry event without hit");

    a_ent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.event_res != EV_ENTRY |->
            rsp_data.entrance_x == '0 && rsp_data.entrance_y == '0 &&
            rsp_data.entrance_z == '0)
        else $error("entrance point without entry event");

endmodule

bind entrance_proximity_and_box_test epbt_chk u_epbt_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

>>> tb/tb_entrance_proximity_and_box_test.sv
module tb_entrance_proximity_and_box_test;
    import epbt_pkg::*;

    localparam int WATCH_LIMIT = 20000;

    class epbt_scoreboard;
        logic [MULT_W-1:0] mult;
        int                nbox;
        logic [ID_W-1:0]   key [MAX_BOXES];
        longint            cen [MAX_BOXES][3];
        longint            hs [MAX_BOXES][3];
        int                ecnt [MAX_BOXES];
        longint            ept [MAX_BOXES][MAX_ENT][3];
        longint            erad [MAX_BOXES][MAX_ENT];
        bit                nv;
        logic [ID_W-1:0]   nk;
        rsp_item_t         pending [$];
        int                errors;
        int                checked;

        function new();
            mult = MULT_RESET;
            nbox = 0;
            nv = 0;
            nk = '0;
            errors = 0;
            checked = 0;
        endfunction

        function int find(logic [ID_W-1:0] id);
            for (int i = 0; i < nbox; i++)
            begin
                if (key[i] == id)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function longint unsigned adiff(longint a, longint b);
            return (a >= b) ? longint'(a - b) : longint'(b - a);
        endfunction

        function void note(req_item_t it);
            rsp_item_t        r;
            longint           p [3];
            longint           h [3];
            int               idx;
            int               bb;
            int               be;
            bit               found;
            bit               near;
            bit               ins;
            longint unsigned  d;
            longint unsigned  best;
            longint unsigned  a;
            logic [95:0]      s;
            logic [95:0]      lim;
            logic [95:0]      lhs;
            r = '0;
            p[0] = longint'(it.pos_x);
            p[1] = longint'(it.pos_y);
            p[2] = longint'(it.pos_z);
            h[0] = longint'(it.half_x);
            h[1] = longint'(it.half_y);
            h[2] = longint'(it.half_z);
            bb = 0;
            be = 0;
            best = 0;
            found = 0;
            near = 0;
            case (it.action)
                ACT_BOX:
                begin
                    idx = find(it.building_id);
                    if (idx >= 0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            cen[idx][k] = p[k];
                            hs[idx][k] = h[k];
                        end
                        r.status = STAT_UPDATED;
                    end
                    else if (nbox >= MAX_BOXES)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        key[nbox] = it.building_id;
                        for (int k = 0; k < 3; k++)
                        begin
                            cen[nbox][k] = p[k];
                            hs[nbox][k] = h[k];
                        end
                        ecnt[nbox] = 0;
                        nbox++;
                        r.status = STAT_DONE;
                    end
                end
                ACT_ENT:
                begin
                    idx = find(it.building_id);
                    if (idx < 0)
                    begin
                        r.status = STAT_NOTFOUND;
                    end
                    else if (ecnt[idx] >= MAX_ENT)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            ept[idx][ecnt[idx]][k] = p[k];
                        end
                        erad[idx][ecnt[idx]] = longint'(it.radius);
                        ecnt[idx]++;
                        r.status = STAT_DONE;
                    end
                end
                ACT_CHECK:
                begin
                    for (int b = 0; b < nbox; b++)
                    begin
                        for (int e = 0; e < ecnt[b]; e++)
                        begin
                            d = 0;
                            for (int k = 0; k < 3; k++)
                            begin
                                a = adiff(p[k], ept[b][e][k]);
                                d += a * a;
                            end
                            if (!found || d < best)
                            begin
                                found = 1;
                                best = d;
                                bb = b;
                                be = e;
                            end
                        end
                    end
                    if (found)
                    begin
                        s = 96'(erad[bb][be]) * 96'(mult);
                        lim = s * s;
                        lhs = 96'(best) << MULT_SHIFT;
                        near = (lhs <= lim);
                        r.building_out = key[bb];
                    end
                    if (near)
                    begin
                        r.hit = 1'b1;
                        if (!nv || nk != key[bb])
                        begin
                            nv = 1;
                            nk = key[bb];
                            r.event_res = EV_ENTRY;
                            r.entrance_x = ept[bb][be][0][COORD_BITS-1:0];
                            r.entrance_y = ept[bb][be][1][COORD_BITS-1:0];
                            r.entrance_z = ept[bb][be][2][COORD_BITS-1:0];
                        end
                    end
                    else if (nv)
                    begin
                        nv = 0;
                        nk = '0;
                        r.event_res = EV_EXIT;
                    end
                end
                default:
                begin
                    for (int b = 0; b < nbox; b++)
                    begin
                        ins = 1;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (adiff(p[k], cen[b][k]) > longint'(hs[b][k]))
                            begin
                                ins = 0;
                            end
                        end
                        if (ins)
                        begin
                            r.hit = 1'b1;
                            r.building_out = key[b];
                            break;
                        end
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0s: got %0h expected %0h (result %0d)", what, got, want, checked);
        endtask

        task field(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report(what, got, want);
            end
        endtask

        task check(rsp_item_t got);
            rsp_item_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 32'(got.status), 0);
                return;
            end
            w = pending.pop_front();
            field("status", 32'(got.status), 32'(w.status));
            field("hit", 32'(got.hit), 32'(w.hit));
            field("building_out", 32'(got.building_out), 32'(w.building_out));
            field("event_res", 32'(got.event_res), 32'(w.event_res));
            field("entrance_x", 32'(got.entrance_x), 32'(w.entrance_x));
            field("entrance_y", 32'(got.entrance_y), 32'(w.entrance_y));
            field("entrance_z", 32'(got.entrance_z), 32'(w.entrance_z));
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    epbt_req_if req_ch ();
    epbt_rsp_if rsp_ch ();
    epbt_cfg_if cfg_ch ();

    entrance_proximity_and_box_test uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    epbt_scoreboard sb;
    int             hold_len;
    int             idle_cycles;
    int             sent;
    req_item_t      ent_list [$];
    req_item_t      box_list [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCH_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", sb.pending.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic req_item_t mk(logic [1:0] act, logic [7:0] id,
                                     logic [23:0] x, logic [23:0] y, logic [23:0] z,
                                     logic [22:0] hx, logic [22:0] hy, logic [22:0] hz,
                                     logic [22:0] r);
        req_item_t it;
        it.action = act;
        it.building_id = id;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.half_x = hx;
        it.half_y = hy;
        it.half_z = hz;
        it.radius = r;
        return it;
    endfunction

    function automatic logic [23:0] rnd_coord();
        if ($urandom_range(7) == 0)
        begin
            return 24'($urandom);
        end
        return 24'(int'($urandom_range(8191)) - 4096);
    endfunction

    function automatic logic [22:0] rnd_size();
        if ($urandom_range(7) == 0)
        begin
            return 23'($urandom);
        end
        return 23'($urandom_range(2048));
    endfunction

    function automatic logic [23:0] jitter(logic [23:0] v);
        return v + 24'(int'($urandom_range(64)) - 32);
    endfunction

    function automatic req_item_t rnd_item(int id_top, int box_pct, int ent_pct);
        req_item_t it;
        req_item_t src;
        int        pick;
        it = mk(2'($urandom), 8'($urandom_range(id_top)), rnd_coord(), rnd_coord(),
                rnd_coord(), rnd_size(), rnd_size(), rnd_size(), rnd_size());
        pick = $urandom_range(99);
        if (pick < box_pct)
        begin
            it.action = ACT_BOX;
        end
        else if (pick < box_pct + ent_pct)
        begin
            it.action = ACT_ENT;
        end
        else if (pick < box_pct + ent_pct + (100 - box_pct - ent_pct) / 2)
        begin
            it.action = ACT_CHECK;
            if (ent_list.size() > 0 && $urandom_range(3) != 0)
            begin
                src = ent_list[$urandom_range(ent_list.size() - 1)];
                it.pos_x = jitter(src.pos_x);
                it.pos_y = jitter(src.pos_y);
                it.pos_z = jitter(src.pos_z);
            end
        end
        else
        begin
            it.action = ACT_INSIDE;
            if (box_list.size() > 0 && $urandom_range(3) != 0)
            begin
                src = box_list[$urandom_range(box_list.size() - 1)];
                it.pos_x = jitter(src.pos_x);
                it.pos_y = jitter(src.pos_y);
                it.pos_z = jitter(src.pos_z);
            end
        end
        return it;
    endfunction

    task send(req_item_t it);
        int gap;
        gap = $urandom_range(3);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= it;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        sb.note(it);
        sent++;
        if (it.action == ACT_BOX)
        begin
            box_list.push_back(it);
        end
        else if (it.action == ACT_ENT)
        begin
            ent_list.push_back(it);
        end
    endtask

    task drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task write_mult(logic [15:0] v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.mult = v;
    endtask

    task run_random(int count, int id_top, int box_pct, int ent_pct, int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                hold_len = 400;
            end
            send(rnd_item(id_top, box_pct, ent_pct));
        end
    endtask

    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
            end
            else
            begin
                n = $urandom_range(3);
            end
            if (n > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_ch.valid);
            sb.check(rsp_ch.data);
        end
    end

    initial
    begin
        sb = new();
        hold_len = 0;
        idle_cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        rsp_ch.ready <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(ACT_INSIDE, 8'd0, 24'd0, 24'd0, 24'd0, 0, 0, 0, 0));
        send(mk(ACT_CHECK, 8'd0, 24'd0, 24'd0, 24'd0, 0, 0, 0, 0));
        send(mk(ACT_ENT, 8'd7, 24'd0, 24'd0, 24'd0, 0, 0, 0, 23'd5));
        send(mk(ACT_BOX, 8'd0, 24'h800000, 24'h800000, 24'h800000, '1, '1, '1, 0));
        send(mk(ACT_BOX, 8'd255, 24'h7fffff, 24'h7fffff, 24'h7fffff, 0, 0, 0, 0));
        send(mk(ACT_BOX, 8'd0, 24'd0, 24'd0, 24'd0, 23'd100, 23'd100, 23'd100, 0));
        send(mk(ACT_INSIDE, 8'd0, 24'd100, 24'hffff9c, 24'd0, 0, 0, 0, 0));
        send(mk(ACT_INSIDE, 8'd0, 24'd101, 24'd0, 24'd0, 0, 0, 0, 0));
        send(mk(ACT_INSIDE, 8'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 0, 0, 0, 0));
        for (int i = 0; i < 9; i++)
        begin
            send(mk(ACT_ENT, 8'd255, 24'(100 * i), 24'd0, 24'd0, 0, 0, 0, 23'd20));
        end
        send(mk(ACT_ENT, 8'd0, 24'h800000, 24'h7fffff, 24'd0, 0, 0, 0, '1));
        send(mk(ACT_CHECK, 8'd0, 24'd5, 24'd0, 24'd0, 0, 0, 0, 0));
        send(mk(ACT_CHECK, 8'd0, 24'd50, 24'd0, 24'd0, 0, 0, 0, 0));
        send(mk(ACT_CHECK, 8'd0, 24'h800000, 24'h7ffff0, 24'd3, 0, 0, 0, 0));
        send(mk(ACT_CHECK, 8'd0, 24'd350, 24'd7, 24'd0, 0, 0, 0, 0));
        send(mk(ACT_CHECK, 8'd0, 24'd300, 24'd0, 24'd0, 0, 0, 0, 0));

        write_mult(16'd0);
        run_random(60, 15, 15, 25, -1);
        write_mult(16'hffff);
        run_random(60, 15, 15, 25, -1);
        write_mult(16'($urandom));
        run_random(200, 15, 15, 25, 80);
        write_mult(16'd256);
        run_random(100, 31, 15, 20, -1);
        write_mult(16'($urandom_range(128, 1024)));
        run_random(230, 255, 50, 8, 100);

        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d items across table fill, entrance limits and five multipliers;",
                 sent);
        $display("checked %0d results, %0d boxes stored at the end.", sb.checked, sb.nbox);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
